// ----- rtl/first_fit_block_allocator_top_assert.svh -----
// Assertion macros shared by the allocator checkers.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define FFBA_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication.
`define FFBA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- rtl/ffba_pkg.sv -----
// Shared types, constants and the microcode table of the first-fit allocator.
// No dependencies; every other allocator file but the assertion macro header refers to this package.
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF = 64;
  localparam int SIZE_W   = 24;
  localparam int ADDR_W   = 32;
  localparam int IDX_W    = 6;
  localparam int HDR_W    = 8;
  localparam int STATUS_W = 3;
  localparam int S_DATA_W = 32;
  localparam int M_DATA_W = 64;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [ADDR_W-1:0] HEAP_BASE_RST    = 32'h0000_0000;
  localparam logic [HDR_W-1:0]  HEADER_BYTES_RST = 8'd32;
  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST   = 32'hFFFF_FFFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_APPENDED = 3'd1,
    ST_FAILED   = 3'd2,
    ST_FREED    = 3'd3,
    ST_BADINDEX = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE    = 2'd0,
    REG_HEADER_BYTES = 2'd1,
    REG_HEAP_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] heap_base;
    logic [HDR_W-1:0]  header_bytes;
    logic [ADDR_W-1:0] heap_limit;
  } cfg_t;

  typedef struct packed {
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    logic              is_free;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Datapath operations, one per microcode step.
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_SCAN,
    OP_APP_CHK,
    OP_APPEND,
    OP_FAIL,
    OP_REUSE,
    OP_FREE_RD,
    OP_FREE,
    OP_BAD,
    OP_EMIT
  } op_t;

  // Jump conditions.
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_INPUT,
    C_IS_FREE,
    C_EMPTY,
    C_HIT,
    C_MORE,
    C_FAIL,
    C_BAD,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_APP_CHK,
    S_APP_TEST,
    S_APPEND,
    S_FAIL,
    S_REUSE,
    S_FREE_RD,
    S_FREE,
    S_BAD,
    S_EMIT
  } step_t;

  // Jump A is tested first, then jump B; otherwise the step counter advances.
  typedef struct packed {
    op_t   op;
    cond_t cond_a;
    step_t tgt_a;
    cond_t cond_b;
    step_t tgt_b;
  } uword_t;

  typedef struct packed {
    logic in_take;
    logic is_free;
    logic empty;
    logic hit;
    logic more;
    logic fail;
    logic bad;
    logic out_busy;
  } flags_t;

  function automatic uword_t ucode_rom(input step_t pc);
    uword_t w;
    begin
      unique case (pc)
        S_IDLE:     w = '{op: OP_LOAD,    cond_a: C_NO_INPUT, tgt_a: S_IDLE,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_DISPATCH: w = '{op: OP_NOP,     cond_a: C_IS_FREE,  tgt_a: S_FREE_RD,
                          cond_b: C_EMPTY, tgt_b: S_APP_CHK};
        S_SCAN:     w = '{op: OP_SCAN,    cond_a: C_HIT,      tgt_a: S_REUSE,
                          cond_b: C_MORE,  tgt_b: S_SCAN};
        S_APP_CHK:  w = '{op: OP_APP_CHK, cond_a: C_NEVER,    tgt_a: S_IDLE,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_APP_TEST: w = '{op: OP_NOP,     cond_a: C_FAIL,     tgt_a: S_FAIL,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_APPEND:   w = '{op: OP_APPEND,  cond_a: C_ALWAYS,   tgt_a: S_EMIT,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_FAIL:     w = '{op: OP_FAIL,    cond_a: C_ALWAYS,   tgt_a: S_EMIT,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_REUSE:    w = '{op: OP_REUSE,   cond_a: C_ALWAYS,   tgt_a: S_EMIT,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_FREE_RD:  w = '{op: OP_FREE_RD, cond_a: C_BAD,      tgt_a: S_BAD,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_FREE:     w = '{op: OP_FREE,    cond_a: C_ALWAYS,   tgt_a: S_EMIT,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_BAD:      w = '{op: OP_BAD,     cond_a: C_ALWAYS,   tgt_a: S_EMIT,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
        S_EMIT:     w = '{op: OP_EMIT,    cond_a: C_OUT_BUSY, tgt_a: S_EMIT,
                          cond_b: C_ALWAYS, tgt_b: S_IDLE};
        default:    w = '{op: OP_NOP,     cond_a: C_ALWAYS,   tgt_a: S_IDLE,
                          cond_b: C_NEVER, tgt_b: S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

// ----- rtl/ffba_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Uses ffba_pkg only for parameter defaults.
module ffba_ram #(
  parameter int WIDTH = ffba_pkg::ENTRY_W,
  parameter int DEPTH = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/ffba_useq.sv -----
// Microcode sequencer: step counter, control table lookup and jump logic.
// Depends on ffba_pkg for the control word, conditions and the table.
module ffba_useq (
  input  logic             clk,
  input  logic             rst,
  input  ffba_pkg::flags_t flags,
  output ffba_pkg::op_t    op
);

  ffba_pkg::step_t  pc;
  ffba_pkg::step_t  pc_next;
  ffba_pkg::uword_t uw;

  function automatic logic cond_true(input ffba_pkg::cond_t c, input ffba_pkg::flags_t f);
    logic r;
    begin
      unique case (c)
        ffba_pkg::C_NEVER:    r = 1'b0;
        ffba_pkg::C_ALWAYS:   r = 1'b1;
        ffba_pkg::C_NO_INPUT: r = !f.in_take;
        ffba_pkg::C_IS_FREE:  r = f.is_free;
        ffba_pkg::C_EMPTY:    r = f.empty;
        ffba_pkg::C_HIT:      r = f.hit;
        ffba_pkg::C_MORE:     r = f.more;
        ffba_pkg::C_FAIL:     r = f.fail;
        ffba_pkg::C_BAD:      r = f.bad;
        ffba_pkg::C_OUT_BUSY: r = f.out_busy;
        default:              r = 1'b0;
      endcase
      return r;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ffba_pkg::S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  always_comb begin
    uw = ffba_pkg::ucode_rom(pc);
    op = uw.op;
    if (cond_true(uw.cond_a, flags)) begin
      pc_next = uw.tgt_a;
    end else if (cond_true(uw.cond_b, flags)) begin
      pc_next = uw.tgt_b;
    end else begin
      pc_next = ffba_pkg::step_t'(pc + 4'd1);
    end
  end

endmodule

// ----- rtl/ffba_dp.sv -----
// Allocator datapath: request capture, table scan, heap arithmetic and the
// result register. Driven by ffba_useq; holds the block table in ffba_ram.
module ffba_dp #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ffba_pkg::op_t                 op,
  input  ffba_pkg::cfg_t                cfg,
  output ffba_pkg::flags_t              flags,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [ffba_pkg::S_DATA_W-1:0] s_tdata,
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [ffba_pkg::M_DATA_W-1:0] m_tdata,
  output logic [ffba_pkg::STATUS_W-1:0] m_tuser
);

  localparam int IW   = $clog2(MAX_BLOCKS);
  localparam int CW   = IW + 1;
  localparam int CMPW = (CW > ffba_pkg::IDX_W) ? CW : ffba_pkg::IDX_W;
  localparam int SW   = ffba_pkg::SIZE_W;
  localparam int AW   = ffba_pkg::ADDR_W;
  localparam int XW   = ffba_pkg::IDX_W;

  // Captured request
  logic          kind_q;
  logic [SW-1:0] want_q;
  logic [XW-1:0] idx_q;

  // Scan state: ptr is the next read address, chk_idx the entry now on rdata.
  logic [CW-1:0] ptr;
  logic [IW-1:0] chk_idx;
  logic          chk_vld;
  ffba_pkg::entry_t ent_q;
  logic [IW-1:0] ent_idx;

  logic [CW-1:0] cnt;
  logic [AW-1:0] heap_used;
  logic [AW-1:0] need_q;
  logic [AW-1:0] top_q;
  logic          fail_q;

  ffba_pkg::status_t res_status;
  logic [XW-1:0]     res_idx;
  logic [AW-1:0]     res_addr;
  logic [SW-1:0]     res_size;

  ffba_pkg::status_t out_status;
  logic [XW-1:0]     out_idx;
  logic [AW-1:0]     out_addr;
  logic [SW-1:0]     out_size;

  logic [ffba_pkg::ENTRY_W-1:0] ram_rdata;
  logic [ffba_pkg::ENTRY_W-1:0] ram_wdata;
  ffba_pkg::entry_t rd_entry;
  ffba_pkg::entry_t wr_entry;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [IW-1:0]    ram_raddr;

  logic [CMPW-1:0] idx_ext;
  logic [CMPW-1:0] cnt_ext;
  logic [CMPW-1:0] ent_idx_ext;
  logic [AW:0]     need;
  logic [AW-1:0]   addr_new;
  logic            in_take;
  logic            out_busy;
  logic            hit;
  logic            bad;

  assign rd_entry    = ffba_pkg::entry_t'(ram_rdata);
  assign ram_wdata   = wr_entry;
  assign idx_ext     = CMPW'(idx_q);
  assign cnt_ext     = CMPW'(cnt);
  assign ent_idx_ext = CMPW'(ent_idx);

  assign s_tready = (op == ffba_pkg::OP_LOAD);
  assign in_take  = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;

  assign hit  = chk_vld && rd_entry.is_free && (rd_entry.size >= want_q);
  assign bad  = (idx_ext >= cnt_ext);
  assign need = (AW+1)'(heap_used) + (AW+1)'(cfg.header_bytes) + (AW+1)'(want_q);
  assign addr_new = top_q + AW'(cfg.header_bytes);

  always_comb begin
    flags.in_take  = in_take;
    flags.is_free  = kind_q;
    flags.empty    = (cnt == '0);
    flags.hit      = hit;
    flags.more     = !(chk_vld && (CW'({1'b0, chk_idx}) == cnt - CW'(1)));
    flags.fail     = fail_q;
    flags.bad      = bad;
    flags.out_busy = out_busy;
  end

  // Table port selection
  always_comb begin
    ram_raddr = ptr[IW-1:0];
    ram_we    = 1'b0;
    ram_waddr = cnt[IW-1:0];
    wr_entry  = '{size: want_q, addr: addr_new, is_free: 1'b0};
    case (op)
      ffba_pkg::OP_FREE_RD: begin
        ram_raddr = idx_ext[IW-1:0];
      end
      ffba_pkg::OP_APPEND: begin
        ram_we = 1'b1;
      end
      ffba_pkg::OP_REUSE: begin
        ram_we    = 1'b1;
        ram_waddr = ent_idx;
        wr_entry  = '{size: ent_q.size, addr: ent_q.addr, is_free: 1'b0};
      end
      ffba_pkg::OP_FREE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_ext[IW-1:0];
        wr_entry  = '{size: rd_entry.size, addr: rd_entry.addr, is_free: 1'b1};
      end
      default: begin
      end
    endcase
  end

  ffba_ram #(
    .WIDTH(ffba_pkg::ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      heap_used <= '0;
      chk_vld   <= 1'b0;
      ptr       <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      case (op)
        ffba_pkg::OP_LOAD: begin
          ptr     <= '0;
          chk_vld <= 1'b0;
        end
        ffba_pkg::OP_SCAN: begin
          ptr     <= ptr + CW'(1);
          chk_vld <= (ptr < cnt);
        end
        ffba_pkg::OP_APPEND: begin
          cnt       <= cnt + CW'(1);
          heap_used <= need_q;
        end
        default: begin
        end
      endcase
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (op == ffba_pkg::OP_EMIT && !out_busy) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      kind_q <= s_tuser;
      want_q <= s_tdata[SW-1:0];
      idx_q  <= s_tdata[SW+XW-1:SW];
    end
    case (op)
      ffba_pkg::OP_SCAN: begin
        chk_idx <= ptr[IW-1:0];
        ent_q   <= rd_entry;
        ent_idx <= chk_idx;
      end
      ffba_pkg::OP_APP_CHK: begin
        need_q <= need[AW-1:0];
        top_q  <= cfg.heap_base + heap_used;
        fail_q <= (cnt == CW'(MAX_BLOCKS)) || (need > {1'b0, cfg.heap_limit});
      end
      ffba_pkg::OP_APPEND: begin
        res_status <= ffba_pkg::ST_APPENDED;
        res_idx    <= cnt_ext[XW-1:0];
        res_addr   <= addr_new;
        res_size   <= want_q;
      end
      ffba_pkg::OP_FAIL: begin
        res_status <= ffba_pkg::ST_FAILED;
        res_idx    <= '0;
        res_addr   <= '0;
        res_size   <= '0;
      end
      ffba_pkg::OP_REUSE: begin
        res_status <= ffba_pkg::ST_REUSED;
        res_idx    <= ent_idx_ext[XW-1:0];
        res_addr   <= ent_q.addr;
        res_size   <= ent_q.size;
      end
      ffba_pkg::OP_FREE: begin
        res_status <= ffba_pkg::ST_FREED;
        res_idx    <= idx_q;
        res_addr   <= rd_entry.addr;
        res_size   <= rd_entry.size;
      end
      ffba_pkg::OP_BAD: begin
        res_status <= ffba_pkg::ST_BADINDEX;
        res_idx    <= idx_q;
        res_addr   <= '0;
        res_size   <= '0;
      end
      default: begin
      end
    endcase
    if (op == ffba_pkg::OP_EMIT && !out_busy) begin
      out_status <= res_status;
      out_idx    <= res_idx;
      out_addr   <= res_addr;
      out_size   <= res_size;
    end
  end

  assign m_tdata = {2'b00, out_size, out_addr, out_idx};
  assign m_tuser = out_status;

endmodule

// ----- rtl/first_fit_block_allocator_top.sv -----
// First-fit block allocator, one request at a time. An allocate request scans the table
// one entry per cycle and reuses the first free entry that is large enough; otherwise it
// appends a new block, or fails when the table is full or the heap limit would be passed.
// The next request is taken only after the result enters the output register; a result
// is held back while the previous one is unread.
// Synchronous reset empties the table and heap, restores defaults; the RAM is not cleared.
module first_fit_block_allocator_top #(
  parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ffba_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: [23:0] request_size, [29:24] block_index, [31:30] zero
  input  logic [ffba_pkg::S_DATA_W-1:0]   s_tdata,
  // s_tuser: [0] kind
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: [5:0] result_index, [37:6] block_address, [61:38] recorded_size,
  // [63:62] zero
  output logic [ffba_pkg::M_DATA_W-1:0]   m_tdata,
  // m_tuser: [2:0] status
  output logic [ffba_pkg::STATUS_W-1:0]   m_tuser
);

  ffba_pkg::cfg_t   cfg;
  ffba_pkg::flags_t flags;
  ffba_pkg::op_t    op;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.heap_base    <= ffba_pkg::HEAP_BASE_RST;
      cfg.header_bytes <= ffba_pkg::HEADER_BYTES_RST;
      cfg.heap_limit   <= ffba_pkg::HEAP_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ffba_pkg::REG_HEAP_BASE:    cfg.heap_base    <= cfg_data;
        ffba_pkg::REG_HEADER_BYTES: cfg.header_bytes <= cfg_data[ffba_pkg::HDR_W-1:0];
        ffba_pkg::REG_HEAP_LIMIT:   cfg.heap_limit   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ffba_useq u_useq (
    .clk  (clk),
    .rst  (rst),
    .flags(flags),
    .op   (op)
  );

  ffba_dp #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .cfg     (cfg),
    .flags   (flags),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule

// ----- rtl/ffba_chk.sv -----
// Port-level checker for the allocator, bound to the top level.
// Depends on ffba_pkg and the assertion macro header.
`include "first_fit_block_allocator_top_assert.svh"

module ffba_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ffba_pkg::M_DATA_W-1:0]   m_tdata,
  input logic [ffba_pkg::STATUS_W-1:0]   m_tuser
);

  // A result waiting for the sink stays offered.
  `FFBA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

  `FFBA_ASSERT_NEXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser))

  // Only one request is in work at a time, so ready drops after each request.
  `FFBA_ASSERT_NEXT(a_one_request, s_tvalid && s_tready, !s_tready)

  // A failed allocation reports no block.
  `FFBA_ASSERT_IMPL(a_fail_zero, m_tvalid && (m_tuser == ffba_pkg::ST_FAILED), m_tdata == '0)

endmodule

bind first_fit_block_allocator_top ffba_chk u_ffba_chk (.*);
